// ===== rtl/fnfba_pkg.sv =====
// shared codes, states and control structs of the first/next fit block allocator
`default_nettype none

package fnfba_pkg;

  // action codes carried in the input word
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  // status codes of a result word
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_FIT      = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

  // register select (byte address bit 2)
  localparam logic REG_ARENA = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  // arena size after reset
  localparam logic [15:0] ARENA_RESET = 16'd65532;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SPLIT,
    S_SH_RD,
    S_SH_WR,
    S_WR_REM,
    S_WR_PICK,
    S_FREE_WR,
    S_INIT,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch request, set up scan
    logic rd_scan;   // read table at scan index
    logic step;      // advance scan index
    logic take;      // capture hit entry
    logic sh_init;   // start shift at table end
    logic rd_shift;  // read entry below shift index
    logic wr_shift;  // write it one slot up
    logic wr_rem;    // write free remainder after pick
    logic wr_pick;   // write picked entry as used
    logic wr_free;   // write matched entry as free
    logic wr_init;   // restore single free block
    logic addr_ok;   // result carries picked offset
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;      // current entry fits or matches
    logic used;     // current entry is in use
    logic last;     // current entry is the last to scan
    logic rest_nz;  // picked block needs a split
    logic full;     // table holds the maximum entries
    logic sh_more;  // entries left to move up
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/fnfba_ctrl.sv =====
// sequencer of the allocator: scan, split, shift and result hand-off
`default_nettype none

module fnfba_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire  [1:0]          action_i,
  input  wire                 out_free_i,
  input  fnfba_pkg::sts_t     sts_i,
  output fnfba_pkg::cmd_t     cmd_o,
  output logic                in_ready_o,
  output logic                res_valid_o,
  output logic [2:0]          res_status_o
);
  import fnfba_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;
  logic [1:0] act_q, act_d;
  logic       ok_q, ok_d;

  // state and result code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      act_q   <= ACT_ALLOC;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      act_q   <= act_d;
      ok_q    <= ok_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    act_d       = act_q;
    ok_d        = ok_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          act_d      = action_i;
          code_d     = ST_OK;
          ok_d       = 1'b0;
          unique case (action_i)
            ACT_ALLOC, ACT_FREE: state_d = S_RD;
            ACT_INIT:            state_d = S_INIT;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        if (sts_i.hit) begin
          cmd_o.take = 1'b1;
          if (act_q == ACT_ALLOC) begin
            state_d = S_SPLIT;
          end else if (sts_i.used) begin
            state_d = S_FREE_WR;
          end else begin
            code_d  = ST_DOUBLE_FREE;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            code_d  = (act_q == ACT_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_SPLIT: begin
        if (!sts_i.rest_nz) begin
          state_d = S_WR_PICK;
        end else if (sts_i.full) begin
          code_d  = ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.sh_init = 1'b1;
          state_d       = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (sts_i.sh_more) begin
          cmd_o.rd_shift = 1'b1;
          state_d        = S_SH_WR;
        end else begin
          state_d = S_WR_REM;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_SH_RD;
      end
      S_WR_REM: begin
        cmd_o.wr_rem = 1'b1;
        state_d      = S_WR_PICK;
      end
      S_WR_PICK: begin
        cmd_o.wr_pick = 1'b1;
        ok_d          = 1'b1;
        state_d       = S_DONE;
      end
      S_FREE_WR: begin
        cmd_o.wr_free = 1'b1;
        state_d       = S_DONE;
      end
      S_INIT: begin
        cmd_o.wr_init = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.addr_ok = ok_q;
  end

  assign res_status_o = code_q;

endmodule

`default_nettype wire

// ===== rtl/fnfba_dp.sv =====
// block table memory, scan and shift counters, fit and match compare
`default_nettype none

module fnfba_dp #(
  parameter int MAX_BLOCKS  = 64,
  parameter int OFFSET_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fnfba_pkg::cmd_t     cmd_i,
  output fnfba_pkg::sts_t     sts_o,
  input  wire  [1:0]          action_i,
  input  wire  [15:0]         request_size_i,
  input  wire  [15:0]         block_address_i,
  input  wire  [15:0]         arena_size_i,
  input  wire                 fit_mode_i,
  output logic [15:0]         res_addr_o,
  output logic [6:0]          block_count_o
);
  import fnfba_pkg::*;

  localparam int IDXW = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int CW   = (OFFSET_BITS > 17) ? OFFSET_BITS : 17;
  localparam int OB   = OFFSET_BITS;
  localparam int EW   = 2 * OFFSET_BITS + 1;
  localparam logic [63:0] MAXA  = ((64'd1 << OFFSET_BITS) - 64'd1) & ~64'd3;
  localparam logic [63:0] RST_A = ({48'd0, ARENA_RESET} > MAXA) ? MAXA
                                                                 : {48'd0, ARENA_RESET};
  localparam logic [CNTW-1:0] MAXN = CNTW'(MAX_BLOCKS);

  // entry word: {used, size, offset}
  logic [EW-1:0]   mem [MAX_BLOCKS];
  logic [EW-1:0]   rdata_q;
  logic            rd_fresh_q;
  logic            fresh_q;
  logic [CNTW-1:0] count_q;
  logic [IDXW-1:0] rover_q;
  logic [CW-1:0]   need_q;
  logic [CW-1:0]   where_q;
  logic            alloc_q;
  logic [IDXW-1:0] idx_q;
  logic [CNTW-1:0] left_q;
  logic [IDXW-1:0] pick_q;
  logic [EW-1:0]   pick_ent_q;
  logic [CNTW-1:0] sh_q;

  logic [EW-1:0]   entry;
  logic [CW-1:0]   e_off, e_size, p_off, p_size;
  logic            e_used;
  logic [16:0]     need17, arena17;
  logic [CW-1:0]   arena_x, maxa_x, init_sel;
  logic [CW-1:0]   rest, rem_off;
  logic [IDXW-1:0] start, idx_next, raddr, waddr;
  logic [CNTW-1:0] sh_dec, pick_inc;
  logic [EW-1:0]   wdata;
  logic            re, we;
  logic [31:0]     cnt32;

  // entry 0 reads as the reset block until first written
  assign entry  = rd_fresh_q ? {1'b0, RST_A[OB-1:0], {OB{1'b0}}} : rdata_q;
  assign e_off  = CW'(entry[OB-1:0]);
  assign e_size = CW'(entry[2*OB-1:OB]);
  assign e_used = entry[2*OB];
  assign p_off  = CW'(pick_ent_q[OB-1:0]);
  assign p_size = CW'(pick_ent_q[2*OB-1:OB]);

  // request rounding and re-init block size
  assign need17   = ({1'b0, request_size_i} + 17'd3) & ~17'd3;
  assign arena17  = ({1'b0, arena_size_i} + 17'd3) & ~17'd3;
  assign arena_x  = CW'(arena17);
  assign maxa_x   = MAXA[CW-1:0];
  assign init_sel = (arena_x > maxa_x) ? maxa_x : arena_x;

  // scan start: rover for allocate in next fit, else head
  assign start = ((action_i == ACT_ALLOC) && fit_mode_i && (CNTW'(rover_q) < count_q))
                 ? rover_q : '0;
  assign idx_next = (CNTW'(idx_q) == count_q - CNTW'(1)) ? '0 : idx_q + IDXW'(1);

  // split arithmetic
  assign rest     = p_size - need_q;
  assign rem_off  = p_off + need_q;
  assign sh_dec   = sh_q - CNTW'(1);
  assign pick_inc = CNTW'(pick_q) + CNTW'(1);

  // status to controller
  always_comb begin
    sts_o.hit     = alloc_q ? (!e_used && (e_size >= need_q)) : (e_off == where_q);
    sts_o.used    = e_used;
    sts_o.last    = (left_q == CNTW'(1));
    sts_o.rest_nz = (p_size != need_q);
    sts_o.full    = (count_q >= MAXN);
    sts_o.sh_more = (sh_q > pick_inc);
  end

  // memory read port
  assign re    = cmd_i.rd_scan | cmd_i.rd_shift;
  assign raddr = cmd_i.rd_shift ? sh_dec[IDXW-1:0] : idx_q;

  // memory write port
  always_comb begin
    we    = 1'b1;
    waddr = pick_q;
    wdata = pick_ent_q;
    priority if (cmd_i.wr_shift) begin
      waddr = sh_q[IDXW-1:0];
      wdata = entry;
    end else if (cmd_i.wr_rem) begin
      waddr = pick_q + IDXW'(1);
      wdata = {1'b0, rest[OB-1:0], rem_off[OB-1:0]};
    end else if (cmd_i.wr_pick) begin
      wdata = {1'b1, need_q[OB-1:0], pick_ent_q[OB-1:0]};
    end else if (cmd_i.wr_free) begin
      wdata = {1'b0, pick_ent_q[2*OB-1:0]};
    end else if (cmd_i.wr_init) begin
      waddr = '0;
      wdata = {1'b0, init_sel[OB-1:0], {OB{1'b0}}};
    end else begin
      we = 1'b0;
    end
  end

  // table storage
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= 1'b1;
      rd_fresh_q <= 1'b0;
      count_q    <= CNTW'(1);
      rover_q    <= '0;
    end else begin
      if (re) begin
        rd_fresh_q <= fresh_q && (raddr == '0);
      end
      if (we && (waddr == '0)) begin
        fresh_q <= 1'b0;
      end
      if (cmd_i.wr_init) begin
        count_q <= CNTW'(1);
        rover_q <= '0;
      end else begin
        if (cmd_i.wr_rem) begin
          count_q <= count_q + CNTW'(1);
        end
        if (cmd_i.wr_pick) begin
          rover_q <= pick_q;
        end
      end
    end
  end

  // request, scan and shift working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      need_q  <= CW'(need17);
      where_q <= CW'(block_address_i);
      alloc_q <= (action_i == ACT_ALLOC);
      idx_q   <= start;
      left_q  <= count_q;
    end else if (cmd_i.step) begin
      idx_q  <= idx_next;
      left_q <= left_q - CNTW'(1);
    end
    if (cmd_i.take) begin
      pick_q     <= idx_q;
      pick_ent_q <= entry;
    end
    if (cmd_i.sh_init) begin
      sh_q <= count_q;
    end else if (cmd_i.wr_shift) begin
      sh_q <= sh_dec;
    end
  end

  // result fields
  assign res_addr_o    = cmd_i.addr_ok ? p_off[15:0] : 16'd0;
  assign cnt32         = 32'(count_q);
  assign block_count_o = cnt32[6:0];

endmodule

`default_nettype wire

// ===== rtl/first_next_fit_block_allocator.sv =====
// top level: stream ports, config registers, result register, controller and datapath
// work per word: allocate scans entries for a fit and, on a split, moves later entries up one
//   slot; free scans for a matching offset; re-init rewrites the single free block
// one word at a time: the next is taken the cycle after its result is registered,
//   and the result waits while the output register is still full
// reset: table holds one free block of 65532 bytes (capped to the offset width),
//   arena_size 65532, first fit; no clearing pass, the block is ready at once
`default_nettype none

module first_next_fit_block_allocator #(
  parameter int MAX_BLOCKS  = 64,
  parameter int OFFSET_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input word
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // action[1:0], request_size[17:2], block_address[33:18]
  // result word
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[2:0], address[18:3], block_count[25:19]
  // config port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fnfba_pkg::*;

  logic [15:0] arena_q;
  logic        mode_q;
  logic        out_valid_q;
  logic [25:0] out_data_q;
  logic        apb_wr;
  logic        out_free;
  logic        res_valid;
  logic [2:0]  res_status;
  logic [15:0] res_addr;
  logic [6:0]  block_count;
  cmd_t        cmd;
  sts_t        sts;

  // config registers
  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : {16'd0, arena_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= ARENA_RESET;
      mode_q  <= 1'b0;
    end else if (apb_wr) begin
      if (paddr[2] == REG_MODE) begin
        mode_q <= pwdata[0];
      end else begin
        arena_q <= pwdata[15:0];
      end
    end
  end

  fnfba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .action_i     (s_axis_tdata[1:0]),
    .out_free_i   (out_free),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .in_ready_o   (s_axis_tready),
    .res_valid_o  (res_valid),
    .res_status_o (res_status)
  );

  fnfba_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (s_axis_tdata[1:0]),
    .request_size_i  (s_axis_tdata[17:2]),
    .block_address_i (s_axis_tdata[33:18]),
    .arena_size_i    (arena_q),
    .fit_mode_i      (mode_q),
    .res_addr_o      (res_addr),
    .block_count_o   (block_count)
  );

  // result word register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= {block_count, res_addr, res_status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

`ifndef SYNTH
  // a taken word starts work, no second word enters meanwhile
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is in work");

  // a result only lands in a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");

  // table never grows past its capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(block_count) <= 32'(MAX_BLOCKS)) || (MAX_BLOCKS > 127))
    else $error("block count beyond table size");

  // results with a failing status report address zero
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK)) |-> (m_axis_tdata[18:3] == 16'd0))
    else $error("address given with a failing status");
`endif

endmodule

`default_nettype wire
